// ===== rtl/i2a_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// i2a_pkg
// shared types and constants for the signed integer to decimal ascii block
// ----------------------------------------------------------------------------
package i2a_pkg;

    localparam int ValueW       = 32;
    localparam int NumDigits    = 10;
    localparam int DigitW       = 4;
    localparam int BcdW         = NumDigits * DigitW;
    localparam int NumStages    = 4;
    localparam int BitsPerStage = ValueW / NumStages;
    localparam int IdxW         = 4;
    localparam int CharW        = 6;

    localparam logic [CharW-1:0]  CharZero  = 6'd48;
    localparam logic [CharW-1:0]  CharMinus = 6'd45;
    localparam logic [DigitW-1:0] DabbleMin = 4'd5;
    localparam logic [DigitW-1:0] DabbleAdd = 4'd3;

    // one number in flight through the conversion pipeline
    typedef struct packed {
        logic              neg;
        logic [BcdW-1:0]   bcd;
        logic [ValueW-1:0] bin;
    } word_t;

endpackage

`default_nettype wire

// ===== rtl/i2a_dabble_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// i2a_dabble_stage
// one registered slice of the binary to bcd shift-and-add-3 conversion
// ----------------------------------------------------------------------------
module i2a_dabble_stage (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire i2a_pkg::word_t in_word,
    output logic                out_valid,
    input  wire logic           out_ready,
    output i2a_pkg::word_t      out_word
);

    logic           valid_reg;
    i2a_pkg::word_t word_reg;
    i2a_pkg::word_t word_next;

    // shift in the next slice of bits, correcting digits before each shift
    always_comb
    begin
        logic [i2a_pkg::BcdW-1:0]   bcd;
        logic [i2a_pkg::ValueW-1:0] bin;
        bcd = in_word.bcd;
        bin = in_word.bin;
        for (int s = 0; s < i2a_pkg::BitsPerStage; s++)
        begin
            for (int d = 0; d < i2a_pkg::NumDigits; d++)
            begin
                if (bcd[d*i2a_pkg::DigitW +: i2a_pkg::DigitW] >= i2a_pkg::DabbleMin)
                begin
                    bcd[d*i2a_pkg::DigitW +: i2a_pkg::DigitW] =
                        bcd[d*i2a_pkg::DigitW +: i2a_pkg::DigitW] + i2a_pkg::DabbleAdd;
                end
            end
            bcd = {bcd[i2a_pkg::BcdW-2:0], bin[i2a_pkg::ValueW-1]};
            bin = {bin[i2a_pkg::ValueW-2:0], 1'b0};
        end
        word_next.neg = in_word.neg;
        word_next.bcd = bcd;
        word_next.bin = bin;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

`default_nettype wire

// ===== rtl/i2a_serializer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// i2a_serializer
// turns one converted number into a run of characters, one per transfer
// ----------------------------------------------------------------------------
module i2a_serializer (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire i2a_pkg::word_t              in_word,
    output logic [i2a_pkg::CharW-1:0]        ascii_char,
    output logic                             last,
    output logic                             char_valid,
    input  wire logic                        char_stall
);

    logic                        busy_reg;
    logic                        busy_next;
    logic                        minus_reg;
    logic                        minus_next;
    logic [i2a_pkg::IdxW-1:0]    idx_reg;
    logic [i2a_pkg::IdxW-1:0]    idx_next;
    logic [i2a_pkg::BcdW-1:0]    digits_reg;
    logic [i2a_pkg::CharW-1:0]   char_reg;
    logic [i2a_pkg::CharW-1:0]   char_next;
    logic                        last_reg;
    logic                        last_next;
    logic                        valid_reg;
    logic [i2a_pkg::IdxW-1:0]    top_idx;
    logic [i2a_pkg::DigitW-1:0]  cur_digit;
    logic                        out_load;
    logic                        emit;
    logic                        fin;
    logic                        load;

    // highest nonzero digit, zero shows as one digit
    always_comb
    begin
        top_idx = '0;
        for (int d = 1; d < i2a_pkg::NumDigits; d++)
        begin
            if (in_word.bcd[d*i2a_pkg::DigitW +: i2a_pkg::DigitW] != '0)
            begin
                top_idx = i2a_pkg::IdxW'(d);
            end
        end
    end

    assign cur_digit = digits_reg[{idx_reg, 2'b00} +: i2a_pkg::DigitW];
    assign out_load  = !valid_reg || !char_stall;
    assign emit      = busy_reg && out_load;
    assign fin       = emit && !minus_reg && (idx_reg == '0);
    assign in_ready  = !busy_reg || fin;
    assign load      = in_valid && in_ready;

    always_comb
    begin
        busy_next  = busy_reg;
        minus_next = minus_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            busy_next  = 1'b1;
            minus_next = in_word.neg;
            idx_next   = top_idx;
        end
        else if (emit)
        begin
            if (minus_reg)
            begin
                minus_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg - 1'b1;
            end
            if (fin)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        if (minus_reg)
        begin
            char_next = i2a_pkg::CharMinus;
            last_next = 1'b0;
        end
        else
        begin
            char_next = i2a_pkg::CharZero + {2'b00, cur_digit};
            last_next = (idx_reg == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            if (out_load)
            begin
                valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        minus_reg <= minus_next;
        idx_reg   <= idx_next;
        if (load)
        begin
            digits_reg <= in_word.bcd;
        end
        if (emit)
        begin
            char_reg <= char_next;
            last_reg <= last_next;
        end
    end

    assign ascii_char = char_reg;
    assign last       = last_reg;
    assign char_valid = valid_reg;

endmodule

`default_nettype wire

// ===== rtl/signed_int_to_decimal_ascii.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// converts a signed 32-bit integer to its decimal ascii text, minus sign
// first when negative, leading zeros dropped, last marks the final character
// ----------------------------------------------------------------------------
//
//  channel  | valid       | stall       | payload
//  ---------+-------------+-------------+---------------------------
//  number   | value_valid | value_stall | value[31:0] signed
//  text     | char_valid  | char_stall  | ascii_char[5:0], last
//
//  a number passes through the magnitude register and then the bcd stages
//  (eight bits each) before the serializer presents its first character;
//  the serializer then sends one character per cycle while the text side
//  does not stall, 1 to 11 characters per number set by its length
//  reset clears only the valid and busy bits; a stall on the text side backs up the
//  pipeline stage by stage and nothing is lost or repeated
//
module signed_int_to_decimal_ascii (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        value_valid,
    output logic                             value_stall,
    input  wire logic signed [31:0]          value,
    output logic                             char_valid,
    input  wire logic                        char_stall,
    output logic [i2a_pkg::CharW-1:0]        ascii_char,
    output logic                             last
);

    // pipeline links: index 0 is the magnitude register, the rest follow
    // each bcd stage
    logic           stg_valid [0:i2a_pkg::NumStages];
    logic           stg_ready [0:i2a_pkg::NumStages];
    i2a_pkg::word_t stg_word  [0:i2a_pkg::NumStages];

    logic           mag_valid_reg;
    i2a_pkg::word_t mag_word_reg;
    i2a_pkg::word_t mag_word_next;
    logic           mag_ready;

    // magnitude: 0 - raw also gives 2147483648 for the most negative value
    always_comb
    begin
        mag_word_next.neg = value[31];
        mag_word_next.bcd = '0;
        mag_word_next.bin = value[31] ? (32'd0 - $unsigned(value)) : $unsigned(value);
    end

    assign mag_ready   = !mag_valid_reg || stg_ready[0];
    assign value_stall = !mag_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_valid_reg <= 1'b0;
        end
        else if (mag_ready)
        begin
            mag_valid_reg <= value_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mag_ready && value_valid)
        begin
            mag_word_reg <= mag_word_next;
        end
    end

    assign stg_valid[0] = mag_valid_reg;
    assign stg_word[0]  = mag_word_reg;

    // binary to bcd, a slice of input bits per stage
    for (genvar g = 0; g < i2a_pkg::NumStages; g++)
    begin : g_dabble
        i2a_dabble_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stg_valid[g]),
            .in_ready  (stg_ready[g]),
            .in_word   (stg_word[g]),
            .out_valid (stg_valid[g+1]),
            .out_ready (stg_ready[g+1]),
            .out_word  (stg_word[g+1])
        );
    end

    // character sequencer with its own output register
    i2a_serializer u_serializer (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (stg_valid[i2a_pkg::NumStages]),
        .in_ready   (stg_ready[i2a_pkg::NumStages]),
        .in_word    (stg_word[i2a_pkg::NumStages]),
        .ascii_char (ascii_char),
        .last       (last),
        .char_valid (char_valid),
        .char_stall (char_stall)
    );

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// drives signed numbers into signed_int_to_decimal_ascii and checks every
// ascii character and its last flag against a decimal text predictor
// ----------------------------------------------------------------------------

// one character of expected text
typedef struct packed {
    logic [i2a_pkg::CharW-1:0] code;
    logic                      fin;
} text_char_t;

class decimal_text_book;

    text_char_t expected_text[$];
    int         mismatches;

    function new();
        mismatches = 0;
    endfunction

    // decimal text of one accepted number, minus sign first when negative
    function void note_number(logic [31:0] num);
        logic [31:0] mag;
        logic [3:0]  digs[$];
        text_char_t  c;
        mag = num[31] ? 32'd0 - num : num;
        do
        begin
            digs.push_front(4'(mag % 32'd10));
            mag = mag / 32'd10;
        end
        while (mag != 32'd0);
        if (num[31])
        begin
            c.code = i2a_pkg::CharMinus;
            c.fin  = 1'b0;
            expected_text.push_back(c);
        end
        foreach (digs[i])
        begin
            c.code = i2a_pkg::CharZero + i2a_pkg::CharW'(digs[i]);
            c.fin  = (i == digs.size() - 1);
            expected_text.push_back(c);
        end
    endfunction

    function int pending();
        return expected_text.size();
    endfunction

    task report(string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task check_char(logic [i2a_pkg::CharW-1:0] code, logic fin);
        text_char_t want;
        if (expected_text.size() == 0)
        begin
            report($sformatf("character %0d (last %0b) with none expected", code, fin));
            return;
        end
        want = expected_text.pop_front();
        if (code !== want.code)
            report($sformatf("ascii_char %0d, expected %0d", code, want.code));
        if (fin !== want.fin)
            report($sformatf("last %0b, expected %0b", fin, want.fin));
    endtask

endclass

module tb;

    logic                      clk;
    logic                      rst_n;
    logic                      value_valid;
    logic                      value_stall;
    logic signed [31:0]        value;
    logic                      char_valid;
    logic                      char_stall;
    logic [i2a_pkg::CharW-1:0] ascii_char;
    logic                      last;

    // idle odds in percent for each side, changed per phase
    int send_idle_pct;
    int recv_idle_pct;

    decimal_text_book book;

    signed_int_to_decimal_ascii DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .value_valid(value_valid),
        .value_stall(value_stall),
        .value      (value),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .ascii_char (ascii_char),
        .last       (last)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // hard stop well past the slowest legal run
    initial
    begin
        #5000000;
        $display("signed_int_to_decimal_ascii verification failed");
        $finish;
    end

    // one number transfer; valid stays high after the transfer so that
    // back-to-back numbers never lower and raise it in the same step
    task automatic send_number(input logic [31:0] num);
        while ($urandom_range(99) < send_idle_pct)
        begin
            value_valid <= 1'b0;
            @(posedge clk);
        end
        value_valid <= 1'b1;
        value       <= num;
        @(posedge clk);
        while (value_stall)
            @(posedge clk);
        book.note_number(num);
    endtask

    // hold off the number side until every character has come out
    task automatic wait_text_drained();
        value_valid <= 1'b0;
        @(posedge clk);
        while (book.pending() != 0)
            @(posedge clk);
    endtask

    // mostly spread over all text lengths, sign chosen at random
    function automatic logic [31:0] pick_number();
        logic [31:0] num;
        num = $urandom() >> $urandom_range(31);
        if ($urandom_range(1) == 1)
            num = 32'd0 - num;
        return num;
    endfunction

    // text side: check each transfer, then pick the stall for the next edge
    initial
    begin
        char_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (char_valid && !char_stall)
                book.check_char(ascii_char, last);
            char_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    initial
    begin
        logic [31:0] corner[$];
        book          = new();
        send_idle_pct = 28;
        recv_idle_pct = 79;
        rst_n         = 1'b0;
        value_valid  <= 1'b0;
        value        <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners: zero, single digits, decade edges, both
        // extremes including the most negative value, alternating bits
        corner = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10,
                   32'd99, 32'd100, -32'sd9, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'h8000_0001, 32'd1000000000, 32'd999999999,
                   -32'sd999999999, 32'd1234567890, -32'sd1000000000,
                   32'h5555_5555, 32'hAAAA_AAAA, 32'd5};
        foreach (corner[i])
            send_number(corner[i]);
        wait_text_drained();

        // sender idles lightly, text side stalls heavily
        repeat (80)
            send_number(pick_number());
        wait_text_drained();

        // roles swapped
        send_idle_pct = 79;
        recv_idle_pct = 28;
        repeat (80)
            send_number(pick_number());
        wait_text_drained();

        // full rate on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (80)
            send_number(pick_number());
        wait_text_drained();

        // wait on to catch any stray character
        repeat (20) @(posedge clk);
        if (book.pending() != 0)
            book.report($sformatf("%0d characters never arrived", book.pending()));
        if (book.mismatches == 0)
            $display("signed_int_to_decimal_ascii verification clean");
        else
            $display("signed_int_to_decimal_ascii verification failed");
        $finish;
    end

endmodule
